@@ src/qsp_pkg.sv @@
// Package for the QPACK static field section parser.
// Types, phase codes, event codes and static length tables. No dependencies.
package qsp_pkg;

    localparam int STATIC_ENTRIES = 99;
    localparam logic [61:0] MASK62 = {62{1'b1}};

    // configuration register indexes
    localparam logic [0:0] REG_MAX_FIELDS = 1'd0;
    localparam logic [0:0] REG_MAX_SIZE   = 1'd1;

    typedef enum logic [3:0] {
        PH_RIC, PH_BASE, PH_BASE_CONT, PH_LINE, PH_IDX_CONT, PH_NREF_CONT,
        PH_NAME_LEN_CONT, PH_NAME_DATA, PH_VAL_FIRST, PH_VAL_LEN_CONT,
        PH_VAL_DATA, PH_ERR
    } phase_t;

    localparam logic [2:0] EV_INDEXED  = 3'd0;
    localparam logic [2:0] EV_NAMEREF  = 3'd1;
    localparam logic [2:0] EV_NAME_HDR = 3'd2;
    localparam logic [2:0] EV_VAL_HDR  = 3'd3;
    localparam logic [2:0] EV_BYTE     = 3'd4;
    localparam logic [2:0] EV_FIELD    = 3'd5;
    localparam logic [2:0] EV_SECTION  = 3'd6;
    localparam logic [2:0] EV_ERROR    = 3'd7;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DECOMP = 2'd1;
    localparam logic [1:0] ERR_MSG    = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  idx;
        logic [61:0] len;
        logic        huff;
        logic [7:0]  data;
        logic [31:0] fields;
        logic [1:0]  err;
        logic        last;
    } event_t;

    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
        event_t     ev2;
    } batch_t;

    function automatic logic [5:0] name_len(input logic [6:0] i);
        logic [5:0] r;
        case (i)
            7'd0: r = 10; 7'd1: r = 5; 7'd2: r = 3; 7'd3: r = 19; 7'd4: r = 14;
            7'd5: r = 6; 7'd6: r = 4; 7'd7: r = 4; 7'd8: r = 17; 7'd9: r = 13;
            7'd10: r = 13; 7'd11: r = 4; 7'd12: r = 8; 7'd13: r = 7; 7'd14: r = 10;
            7'd29: r = 6; 7'd30: r = 6; 7'd31: r = 15; 7'd32: r = 13;
            7'd33: r = 28; 7'd34: r = 28; 7'd35: r = 27;
            7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41: r = 13;
            7'd42, 7'd43: r = 16;
            7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53,
            7'd54: r = 12;
            7'd55: r = 5; 7'd56, 7'd57, 7'd58: r = 25; 7'd59, 7'd60: r = 4;
            7'd61: r = 22; 7'd62: r = 16; 7'd72: r = 15; 7'd73, 7'd74: r = 32;
            7'd75, 7'd76, 7'd77, 7'd78: r = 28; 7'd79: r = 29; 7'd80: r = 30;
            7'd81, 7'd82: r = 29; 7'd83: r = 7; 7'd84: r = 13; 7'd85: r = 23;
            7'd86: r = 10; 7'd87, 7'd88: r = 9; 7'd89: r = 8; 7'd90: r = 6;
            7'd91: r = 7; 7'd92: r = 6; 7'd93: r = 19; 7'd94: r = 25;
            7'd95: r = 10; 7'd96, 7'd97, 7'd98: r = 15;
            default: r = 7;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] value_len(input logic [6:0] i);
        logic [5:0] r;
        case (i)
            7'd1, 7'd2, 7'd4, 7'd35, 7'd75, 7'd86, 7'd93, 7'd94: r = 1;
            7'd15, 7'd19: r = 7; 7'd16: r = 6; 7'd17: r = 3; 7'd18: r = 4;
            7'd20: r = 4; 7'd21: r = 3; 7'd22: r = 4; 7'd23: r = 5;
            7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29: r = 3;
            7'd30: r = 23; 7'd31: r = 17; 7'd32: r = 5; 7'd33: r = 13;
            7'd34: r = 12; 7'd36: r = 9; 7'd37: r = 15; 7'd38: r = 14;
            7'd39, 7'd40: r = 8; 7'd41: r = 24; 7'd42: r = 2; 7'd43: r = 4;
            7'd44: r = 23; 7'd45: r = 22; 7'd46: r = 16; 7'd47: r = 33;
            7'd48: r = 9; 7'd49: r = 10; 7'd50: r = 9; 7'd51: r = 8;
            7'd52: r = 24; 7'd53: r = 10; 7'd54: r = 24; 7'd55: r = 8;
            7'd56: r = 16; 7'd57: r = 35; 7'd58: r = 44; 7'd59: r = 15;
            7'd60: r = 6; 7'd61: r = 7; 7'd62: r = 13;
            7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71: r = 3;
            7'd73: r = 5; 7'd74: r = 4; 7'd76: r = 3; 7'd77: r = 18;
            7'd78: r = 7; 7'd79: r = 14; 7'd80: r = 12; 7'd81: r = 3;
            7'd82: r = 4; 7'd83: r = 5; 7'd85: r = 53; 7'd91: r = 8;
            7'd97: r = 4; 7'd98: r = 10;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic logic lower_token(input logic [7:0] c);
        logic r;
        r = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b, 8'h2d,
            8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ src/qsp_if.sv @@
// Valid/ready stream interfaces for the parser input and output channels.
// Depends on nothing.
interface qsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       end_of_section;
    modport source (output valid, section_byte, end_of_section, input ready);
    modport sink (input valid, section_byte, end_of_section, output ready);
endinterface

interface qsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [6:0]  static_index;
    logic [61:0] literal_length;
    logic        huffman_coded;
    logic [7:0]  literal_data;
    logic [31:0] fields_seen;
    logic [1:0]  error_code;
    logic        last_of_run;
    modport source (output valid, event_kind, static_index, literal_length,
                    huffman_coded, literal_data, fields_seen, error_code,
                    last_of_run, input ready);
    modport sink (input valid, event_kind, static_index, literal_length,
                  huffman_coded, literal_data, fields_seen, error_code,
                  last_of_run, output ready);
endinterface

@@ src/qpack_static_field_section_parser.sv @@
// QPACK static-table field section parser, top level.
// Results are registered in the result queue when their byte is accepted.
// Throughput: one byte per cycle while output drains; input is held off while
// two or more results would stay in the four-entry result queue after this cycle.
// Reset (rst_n, async low) clears parse state, queue and limits to zero.
module qpack_static_field_section_parser
    import qsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qsp_in_if.sink      in_ch,
    qsp_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [61:0] cfg_data
);

    logic [31:0] max_field_count_reg;
    logic [61:0] max_section_size_reg;
    logic        step, space;
    batch_t      batch;
    event_t      head;

    assign in_ch.ready = space;
    assign step = in_ch.valid && space;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_field_count_reg <= '0;
            max_section_size_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_MAX_FIELDS) max_field_count_reg <= cfg_data[31:0];
            else if (cfg_index == REG_MAX_SIZE) max_section_size_reg <= cfg_data;
        end
    end

    qsp_core u_core (
        .clk, .rst_n, .step, .b(in_ch.section_byte), .eos(in_ch.end_of_section),
        .max_field_count(max_field_count_reg),
        .max_section_size(max_section_size_reg), .batch
    );

    qsp_out_queue u_queue (
        .clk, .rst_n, .push(step), .batch, .space,
        .valid(out_ch.valid), .ready(out_ch.ready), .head
    );

    assign out_ch.event_kind = head.kind;
    assign out_ch.static_index = head.idx;
    assign out_ch.literal_length = head.len;
    assign out_ch.huffman_coded = head.huff;
    assign out_ch.literal_data = head.data;
    assign out_ch.fields_seen = head.fields;
    assign out_ch.error_code = head.err;
    assign out_ch.last_of_run = head.last;

endmodule

@@ src/qsp_core.sv @@
// Parse core: per byte state update and up to three events.
// Depends on qsp_pkg.
module qsp_core
    import qsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  b,
    input  logic        eos,
    input  logic [31:0] max_field_count,
    input  logic [61:0] max_section_size,
    output batch_t      batch
);

    phase_t      phase_reg, phase_next;
    logic [61:0] acc_reg, acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic [61:0] rem_reg, rem_next;
    logic        huff_reg, huff_next;
    logic        pos_reg, pos_next;
    logic [63:0] size_reg, size_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        errl_reg, errl_next;
    logic        inv_reg, inv_next;

    event_t ev [3];
    logic [1:0] n;

    // combinational work mirrors the sequential steps; each "call" is short
    always_comb begin
        logic [62:0] add;
        logic [6:0]  ix;
        logic [64:0] s;
        logic        last_b;
        logic        do_idx, do_nref, do_len, len_name, do_fend;
        logic [61:0] len;
        event_t      e;

        phase_next = phase_reg; acc_next = acc_reg; shift_next = shift_reg;
        rem_next = rem_reg; huff_next = huff_reg; pos_next = pos_reg;
        size_next = size_reg; cnt_next = cnt_reg; errl_next = errl_reg;
        inv_next = inv_reg;
        n = 2'd0;
        do_idx = 1'b0; do_nref = 1'b0; do_len = 1'b0; len_name = 1'b0;
        do_fend = 1'b0;
        add = '0; s = '0; len = '0; last_b = 1'b0;
        ix = acc_reg[6:0];
        for (int k = 0; k < 3; k++) ev[k] = '0;
        e = '0;

        if (!errl_reg) begin
            unique case (phase_reg)
                PH_RIC:
                    if (b != 8'd0) begin
                        errl_next = 1'b1; phase_next = PH_ERR;
                    end else phase_next = PH_BASE;
                PH_BASE:
                    if (b[7]) begin
                        errl_next = 1'b1; phase_next = PH_ERR;
                    end else if (b[6:0] != 7'h7f) phase_next = PH_LINE;
                    else begin
                        acc_next = 62'h7f; shift_next = '0; phase_next = PH_BASE_CONT;
                    end
                PH_LINE: begin
                    inv_next = 1'b0;
                    if (b[7]) begin
                        if (!b[6]) begin
                            errl_next = 1'b1; phase_next = PH_ERR;
                        end else begin
                            acc_next = {56'd0, b[5:0]}; shift_next = '0;
                            if (b[5:0] != 6'h3f) do_idx = 1'b1;
                            else phase_next = PH_IDX_CONT;
                        end
                    end else if (b[6]) begin
                        if (!b[4]) begin
                            errl_next = 1'b1; phase_next = PH_ERR;
                        end else begin
                            acc_next = {58'd0, b[3:0]}; shift_next = '0;
                            if (b[3:0] != 4'hf) do_nref = 1'b1;
                            else phase_next = PH_NREF_CONT;
                        end
                    end else if (b[5]) begin
                        huff_next = b[3];
                        acc_next = {59'd0, b[2:0]}; shift_next = '0;
                        if (b[2:0] != 3'h7) begin
                            do_len = 1'b1; len_name = 1'b1;
                        end else phase_next = PH_NAME_LEN_CONT;
                    end else begin
                        errl_next = 1'b1; phase_next = PH_ERR;
                    end
                end
                PH_BASE_CONT, PH_IDX_CONT, PH_NREF_CONT, PH_NAME_LEN_CONT,
                PH_VAL_LEN_CONT: begin
                    add = {1'b0, acc_reg} + ({56'd0, b[6:0]} << shift_reg);
                    if (shift_reg > 6'd62 || add[62] ||
                        (shift_reg > 6'd55 && (b[6:0] >> (6'd62 - shift_reg)) != 0))
                    begin
                        errl_next = 1'b1; phase_next = PH_ERR;
                    end else begin
                        acc_next = add[61:0];
                        if (b[7]) shift_next = shift_reg + 6'd7;
                        else begin
                            case (phase_reg)
                                PH_BASE_CONT: phase_next = PH_LINE;
                                PH_IDX_CONT: do_idx = 1'b1;
                                PH_NREF_CONT: do_nref = 1'b1;
                                PH_NAME_LEN_CONT: begin
                                    do_len = 1'b1; len_name = 1'b1;
                                end
                                default: do_len = 1'b1;
                            endcase
                        end
                    end
                end
                PH_NAME_DATA, PH_VAL_DATA: begin
                    last_b = rem_reg <= 62'd1;
                    e = '0; e.kind = EV_BYTE; e.huff = huff_reg; e.data = b;
                    e.fields = cnt_reg;
                    ev[n] = e; n = n + 2'd1;
                    if (!huff_reg) begin
                        if (phase_reg == PH_NAME_DATA) begin
                            if (!pos_reg && b == 8'h3a) begin
                                if (last_b) inv_next = 1'b1;
                            end else if (!lower_token(b)) inv_next = 1'b1;
                        end else begin
                            if (b == 8'h00 || b == 8'h0d || b == 8'h0a) inv_next = 1'b1;
                            if ((!pos_reg || last_b) && (b == 8'h20 || b == 8'h09))
                                inv_next = 1'b1;
                        end
                    end
                    if (rem_reg != 0) rem_next = rem_reg - 62'd1;
                    pos_next = 1'b1;
                    if (last_b) begin
                        if (phase_reg == PH_NAME_DATA) phase_next = PH_VAL_FIRST;
                        else do_fend = 1'b1;
                    end
                end
                PH_VAL_FIRST: begin
                    huff_next = b[7];
                    acc_next = {55'd0, b[6:0]}; shift_next = '0;
                    if (b[6:0] != 7'h7f) do_len = 1'b1;
                    else phase_next = PH_VAL_LEN_CONT;
                end
                default: begin
                    errl_next = 1'b1; phase_next = PH_ERR;
                end
            endcase
            if (errl_next) begin
                e = '0; e.kind = EV_ERROR; e.err = ERR_DECOMP; e.fields = cnt_reg;
                ev[n] = e; n = n + 2'd1;
            end
        end

        ix = acc_next[6:0];
        if (do_idx || do_nref) begin
            if (acc_next >= 62'(STATIC_ENTRIES)) begin
                errl_next = 1'b1; phase_next = PH_ERR;
                e = '0; e.kind = EV_ERROR; e.err = ERR_DECOMP; e.fields = cnt_reg;
                ev[n] = e; n = n + 2'd1;
            end else begin
                e = '0; e.kind = do_idx ? EV_INDEXED : EV_NAMEREF; e.idx = ix;
                e.fields = cnt_reg;
                ev[n] = e; n = n + 2'd1;
                s = {1'b0, size_reg} + (do_idx ? 65'(name_len(ix)) + 65'(value_len(ix))
                                               : 65'(name_len(ix)));
                size_next = s[64] ? '1 : s[63:0];
                if (do_idx) do_fend = 1'b1;
                else phase_next = PH_VAL_FIRST;
            end
        end

        if (do_len) begin
            len = acc_next;
            e = '0; e.kind = len_name ? EV_NAME_HDR : EV_VAL_HDR; e.len = len;
            e.huff = huff_next; e.fields = cnt_reg;
            ev[n] = e; n = n + 2'd1;
            if (!huff_next && max_section_size != 0 && len > max_section_size) begin
                errl_next = 1'b1; phase_next = PH_ERR;
                e = '0; e.kind = EV_ERROR; e.err = ERR_DECOMP; e.fields = cnt_reg;
                ev[n] = e; n = n + 2'd1;
            end else begin
                if (!huff_next) begin
                    s = {1'b0, size_next} + {3'd0, len};
                    size_next = s[64] ? '1 : s[63:0];
                    if (len_name && len == 0) inv_next = 1'b1;
                end
                if (len == 0) begin
                    if (len_name) phase_next = PH_VAL_FIRST;
                    else do_fend = 1'b1;
                end else begin
                    rem_next = len; pos_next = 1'b0;
                    phase_next = len_name ? PH_NAME_DATA : PH_VAL_DATA;
                end
            end
        end

        if (do_fend) begin
            if (inv_next) begin
                errl_next = 1'b1; phase_next = PH_ERR;
                e = '0; e.kind = EV_ERROR; e.err = ERR_MSG; e.fields = cnt_reg;
                ev[n] = e; n = n + 2'd1;
            end else begin
                if (cnt_reg != '1) cnt_next = cnt_reg + 32'd1;
                s = {1'b0, size_next} + 65'd32;
                size_next = s[64] ? '1 : s[63:0];
                if ((max_field_count != 0 && cnt_next > max_field_count) ||
                    (max_section_size != 0 && size_next > {2'd0, max_section_size}))
                begin
                    errl_next = 1'b1; phase_next = PH_ERR;
                    e = '0; e.kind = EV_ERROR; e.err = ERR_MSG; e.fields = cnt_next;
                end else begin
                    e = '0; e.kind = EV_FIELD; e.fields = cnt_next;
                    phase_next = PH_LINE;
                end
                ev[n] = e; n = n + 2'd1;
            end
        end

        if (eos) begin
            if (!errl_next) begin
                e = '0; e.fields = cnt_next;
                if (phase_next == PH_LINE) e.kind = EV_SECTION;
                else begin
                    e.kind = EV_ERROR; e.err = ERR_DECOMP;
                end
                ev[n] = e; n = n + 2'd1;
            end
            phase_next = PH_RIC; acc_next = '0; shift_next = '0; rem_next = '0;
            huff_next = 1'b0; pos_next = 1'b0; size_next = '0; cnt_next = '0;
            errl_next = 1'b0; inv_next = 1'b0;
        end

        if (n != 0) ev[n - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_RIC; acc_reg <= '0; shift_reg <= '0; rem_reg <= '0;
            huff_reg <= 1'b0; pos_reg <= 1'b0; size_reg <= '0; cnt_reg <= '0;
            errl_reg <= 1'b0; inv_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next; acc_reg <= acc_next; shift_reg <= shift_next;
            rem_reg <= rem_next; huff_reg <= huff_next; pos_reg <= pos_next;
            size_reg <= size_next; cnt_reg <= cnt_next; errl_reg <= errl_next;
            inv_reg <= inv_next;
        end
    end

    assign batch.count = n;
    assign batch.ev0 = ev[0];
    assign batch.ev1 = ev[1];
    assign batch.ev2 = ev[2];

endmodule

@@ src/qsp_out_queue.sv @@
// Result queue: takes a batch of up to three events, hands them out one per cycle while ready is high.
// Depends on qsp_pkg.
module qsp_out_queue
    import qsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  batch_t batch,
    output logic   space,
    output logic   valid,
    input  logic   ready,
    output event_t head
);

    event_t     q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] used_reg;
    logic       pop;
    logic [2:0] used_next;

    assign valid = used_reg != 0;
    assign pop = valid && ready;
    assign head = q_reg[rd_reg];
    // room for a full batch once this cycle's pop is counted
    assign space = (used_reg - {2'd0, pop}) <= 3'd1;
    assign used_next = used_reg - {2'd0, pop} + (push ? {1'b0, batch.count} : 3'd0);

    always_ff @(posedge clk) begin
        if (push) begin
            if (batch.count > 2'd0) q_reg[wr_reg] <= batch.ev0;
            if (batch.count > 2'd1) q_reg[wr_reg + 2'd1] <= batch.ev1;
            if (batch.count > 2'd2) q_reg[wr_reg + 2'd2] <= batch.ev2;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_reg <= '0; wr_reg <= '0; used_reg <= '0;
        end else begin
            if (pop) rd_reg <= rd_reg + 2'd1;
            if (push) wr_reg <= wr_reg + batch.count;
            used_reg <= used_next;
        end
    end

endmodule

@@ src/qsp_checker.sv @@
// Port-level checks for the parser, bound to the top level.
// Depends on qsp_pkg and the top level's port names.
module qsp_checker
    import qsp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_kind,
    input logic [1:0] error_code,
    input logic       last_of_run
);

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_ERROR |-> error_code != ERR_NONE)
        else $error("error event without code");
    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_ERROR |-> error_code == ERR_NONE)
        else $error("code on non-error event");
    a_section_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_SECTION |-> last_of_run)
        else $error("section done not last");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind))
        else $error("stalled result changed");

endmodule

bind qpack_static_field_section_parser qsp_checker u_checker (
    .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .event_kind(out_ch.event_kind), .error_code(out_ch.error_code),
    .last_of_run(out_ch.last_of_run)
);

@@ dv/testbench.sv @@
// Self-checking bench for the QPACK static field section parser.
// Runs directed and random sections against an in-bench parser model, with random
// handshake gaps on both sides. Depends on qsp_pkg, qsp_if and the parser top.
module testbench;
    import qsp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [61:0] cfg_data = '0;

    qsp_in_if  in_ch();
    qsp_out_if out_ch();

    qpack_static_field_section_parser i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

    // static table name / value lengths
    logic [7:0] name_rom [0:98] = '{
        10, 5, 3, 19, 14, 6, 4, 4, 17, 13, 13, 4, 8, 7, 10, 7, 7, 7, 7, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 7, 6, 6, 15, 13, 28, 28, 27, 13, 13, 13, 13,
        13, 13, 16, 16, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 5, 25, 25, 25, 4,
        4, 22, 16, 7, 7, 7, 7, 7, 7, 7, 7, 7, 15, 32, 32, 28, 28, 28, 28, 29,
        30, 29, 29, 7, 13, 23, 10, 9, 9, 8, 6, 7, 6, 19, 25, 10, 15, 15, 15};
    logic [7:0] value_rom [0:98] = '{
        0, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 6, 3, 4, 7,
        4, 3, 4, 5, 3, 3, 3, 3, 3, 3, 23, 17, 5, 13, 12, 1, 9, 15, 14, 8,
        8, 24, 2, 4, 23, 22, 16, 33, 9, 10, 9, 8, 24, 10, 24, 8, 16, 35, 44, 15,
        6, 7, 13, 3, 3, 3, 3, 3, 3, 3, 3, 3, 0, 5, 4, 1, 3, 18, 7, 14,
        12, 3, 4, 5, 0, 53, 1, 0, 0, 0, 0, 8, 0, 1, 1, 0, 0, 4, 10};

    // parser model state
    logic [31:0] lim_fields;
    logic [61:0] lim_size;
    phase_t      ph;
    logic [63:0] acc;
    int unsigned shift;
    logic [63:0] remain;
    bit          lit_huff;
    bit          lit_pos;
    logic [63:0] size_sum;
    logic [31:0] field_cnt;
    bit          err_latched;
    bit          field_bad;

    event_t step_events[$];
    event_t pending_events[$];
    int     mismatches = 0;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    task automatic push_event(logic [2:0] kind, logic [6:0] idx, logic [61:0] len,
                              bit h, logic [7:0] data, logic [1:0] err);
        event_t e;
        if (step_events.size() < 3)
        begin
            e = '{kind: kind, idx: idx, len: len, huff: h, data: data,
                  fields: field_cnt, err: err, last: 1'b0};
            step_events.push_back(e);
        end
    endtask

    task automatic fail_section(logic [1:0] code);
        err_latched = 1;
        ph = PH_ERR;
        push_event(EV_ERROR, 0, 0, 0, 0, code);
    endtask

    task automatic reset_section();
        ph = PH_RIC; acc = 0; shift = 0; remain = 0; lit_huff = 0; lit_pos = 0;
        size_sum = 0; field_cnt = 0; err_latched = 0; field_bad = 0;
    endtask

    function automatic bit int_first(logic [7:0] b, logic [7:0] fit);
        acc = {56'd0, b & fit};
        shift = 0;
        return acc < {56'd0, fit};
    endfunction

    // 0 more bytes, 1 done, 2 overflow
    function automatic int int_next(logic [7:0] c);
        logic [63:0] v;
        if (shift > 62)
            return 2;
        v = acc + ({57'd0, c[6:0]} << shift);
        if (v > {2'b00, MASK62})
            return 2;
        acc = v;
        if (!c[7])
            return 1;
        shift = (shift + 7) & 6'h3f;
        return 0;
    endfunction

    function automatic bit is_token(logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
            return 1;
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~":
                return 1;
            default:
                return 0;
        endcase
    endfunction

    task automatic close_field();
        if (field_bad)
        begin
            fail_section(ERR_MSG);
            return;
        end
        if (field_cnt != 32'hffff_ffff)
            field_cnt++;
        size_sum = sat_sum(size_sum, 32);
        if ((lim_fields != 0 && field_cnt > lim_fields) ||
            (lim_size != 0 && size_sum > {2'b00, lim_size}))
        begin
            fail_section(ERR_MSG);
            return;
        end
        push_event(EV_FIELD, 0, 0, 0, 0, 0);
        ph = PH_LINE;
    endtask

    task automatic indexed_line();
        if (acc >= STATIC_ENTRIES)
        begin
            fail_section(ERR_DECOMP);
            return;
        end
        push_event(EV_INDEXED, acc[6:0], 0, 0, 0, 0);
        size_sum = sat_sum(size_sum, name_rom[acc] + value_rom[acc]);
        close_field();
    endtask

    task automatic name_ref_line();
        if (acc >= STATIC_ENTRIES)
        begin
            fail_section(ERR_DECOMP);
            return;
        end
        push_event(EV_NAMEREF, acc[6:0], 0, 0, 0, 0);
        size_sum = sat_sum(size_sum, name_rom[acc]);
        ph = PH_VAL_FIRST;
    endtask

    task automatic literal_length_known(bit is_name);
        logic [63:0] len;
        len = acc;
        push_event(is_name ? EV_NAME_HDR : EV_VAL_HDR, 0, len[61:0], lit_huff, 0, 0);
        if (!lit_huff)
        begin
            if (lim_size != 0 && len > {2'b00, lim_size})
            begin
                fail_section(ERR_DECOMP);
                return;
            end
            size_sum = sat_sum(size_sum, len);
            if (is_name && len == 0)
                field_bad = 1;
        end
        if (len == 0)
        begin
            if (is_name)
                ph = PH_VAL_FIRST;
            else
                close_field();
            return;
        end
        remain = len;
        lit_pos = 0;
        ph = is_name ? PH_NAME_DATA : PH_VAL_DATA;
    endtask

    task automatic literal_char(bit is_name, logic [7:0] c);
        bit last;
        last = (remain <= 1);
        push_event(EV_BYTE, 0, 0, lit_huff, c, 0);
        if (!lit_huff)
        begin
            if (is_name)
            begin
                if (!lit_pos && c == ":")
                begin
                    if (last)
                        field_bad = 1;
                end
                else if (!is_token(c))
                    field_bad = 1;
            end
            else
            begin
                if (c == 8'h00 || c == 8'h0d || c == 8'h0a)
                    field_bad = 1;
                if ((!lit_pos || last) && (c == 8'h20 || c == 8'h09))
                    field_bad = 1;
            end
        end
        if (remain > 0)
            remain--;
        lit_pos = 1;
        if (remain == 0)
        begin
            if (is_name)
                ph = PH_VAL_FIRST;
            else
                close_field();
        end
    endtask

    task automatic begin_line(logic [7:0] b);
        field_bad = 0;
        if (b[7])
        begin
            if (!b[6])
                fail_section(ERR_DECOMP);
            else if (int_first(b, 8'h3f))
                indexed_line();
            else
                ph = PH_IDX_CONT;
        end
        else if (b[7:6] == 2'b01)
        begin
            if (!b[4])
                fail_section(ERR_DECOMP);
            else if (int_first(b, 8'h0f))
                name_ref_line();
            else
                ph = PH_NREF_CONT;
        end
        else if (b[7:5] == 3'b001)
        begin
            lit_huff = b[3];
            if (int_first(b, 8'h07))
                literal_length_known(1);
            else
                ph = PH_NAME_LEN_CONT;
        end
        else
            fail_section(ERR_DECOMP);
    endtask

    task automatic predict_events(logic [7:0] b, bit eos);
        int r;
        step_events.delete();
        if (!err_latched)
        begin
            case (ph)
                PH_RIC:
                    if (b != 0)
                        fail_section(ERR_DECOMP);
                    else
                        ph = PH_BASE;
                PH_BASE:
                    if (b[7])
                        fail_section(ERR_DECOMP);
                    else if (int_first(b, 8'h7f))
                        ph = PH_LINE;
                    else
                        ph = PH_BASE_CONT;
                PH_LINE:
                    begin_line(b);
                PH_BASE_CONT, PH_IDX_CONT, PH_NREF_CONT, PH_NAME_LEN_CONT, PH_VAL_LEN_CONT:
                begin
                    r = int_next(b);
                    if (r == 2)
                        fail_section(ERR_DECOMP);
                    else if (r == 1)
                    begin
                        case (ph)
                            PH_BASE_CONT:     ph = PH_LINE;
                            PH_IDX_CONT:      indexed_line();
                            PH_NREF_CONT:     name_ref_line();
                            PH_NAME_LEN_CONT: literal_length_known(1);
                            default:          literal_length_known(0);
                        endcase
                    end
                end
                PH_NAME_DATA:
                    literal_char(1, b);
                PH_VAL_FIRST:
                begin
                    lit_huff = b[7];
                    if (int_first(b, 8'h7f))
                        literal_length_known(0);
                    else
                        ph = PH_VAL_LEN_CONT;
                end
                PH_VAL_DATA:
                    literal_char(0, b);
                default:
                    fail_section(ERR_DECOMP);
            endcase
        end
        if (eos)
        begin
            if (!err_latched)
            begin
                if (ph == PH_LINE)
                    push_event(EV_SECTION, 0, 0, 0, 0, 0);
                else
                    fail_section(ERR_DECOMP);
            end
            reset_section();
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i])
            pending_events.push_back(step_events[i]);
    endtask

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // ---------------- drivers ----------------
    bit no_gaps;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_byte(logic [7:0] b, bit eos);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.section_byte <= b;
        in_ch.end_of_section <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_events(b, eos);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [61:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_FIELDS)
            lim_fields = v[31:0];
        else
            lim_size = v;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (no_gaps || $urandom_range(0, 99) < 70)
            out_ch.ready <= 1'b1;
        else
        begin
            out_ch.ready <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        event_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{kind: out_ch.event_kind, idx: out_ch.static_index,
                    len: out_ch.literal_length, huff: out_ch.huffman_coded,
                    data: out_ch.literal_data, fields: out_ch.fields_seen,
                    err: out_ch.error_code, last: out_ch.last_of_run};
            if (pending_events.size() == 0)
                report($sformatf("unexpected event %p", got));
            else
            begin
                want = pending_events.pop_front();
                if (got !== want)
                    report($sformatf("event mismatch: expected %p got %p", want, got));
            end
        end
    end

    // ---------------- random sections ----------------
    logic [7:0] sec[$];

    task automatic put_int(logic [7:0] hi, int bits, logic [63:0] v);
        logic [63:0] fit;
        fit = (64'd1 << bits) - 1;
        if (v < fit)
            sec.push_back(hi | v[7:0]);
        else
        begin
            sec.push_back(hi | fit[7:0]);
            v = v - fit;
            while (v >= 128)
            begin
                sec.push_back({1'b1, v[6:0]});
                v = v >> 7;
            end
            sec.push_back(v[7:0]);
        end
    endtask

    function automatic logic [7:0] pick_char(bit is_name);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range("a", "z"));
        if (r < 85)
            return is_name ? 8'h3a : 8'h20;
        if (r < 88)
            return is_name ? 8'h2d : 8'h09;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_literal(bit is_name);
        bit h;
        int len, n;
        h = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0)
        begin
            len = $urandom_range(45, 70);
            n = 3;
        end
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            n = len;
        end
        if (is_name)
            put_int({4'b0010, h, 3'b000}, 3, len);
        else
            put_int({h, 7'd0}, 7, len);
        repeat (n) sec.push_back(pick_char(is_name));
    endtask

    function automatic int pick_index();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(99, 140) : $urandom_range(0, 98);
    endfunction

    task automatic build_section();
        int r, lines, cut;
        sec.delete();
        sec.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        if ($urandom_range(0, 1))
            sec.push_back(8'h00);
        else if ($urandom_range(0, 9) == 0)
            sec.push_back(8'($urandom_range(128, 255)));
        else
            put_int(8'h00, 7, $urandom_range(0, 300));
        lines = $urandom_range(1, 4);
        repeat (lines)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                put_int(8'hc0, 6, pick_index());
            else if (r < 50)
            begin
                put_int(8'h50, 4, pick_index());
                put_literal(0);
            end
            else if (r < 80)
            begin
                put_literal(1);
                put_literal(0);
            end
            else if (r < 85)
            begin
                case ($urandom_range(0, 2))
                    0:       sec.push_back({2'b10, 6'($urandom)});
                    1:       sec.push_back({4'b0100, 4'($urandom)});
                    default: sec.push_back({3'b000, 5'($urandom)});
                endcase
            end
            else if (r < 88)
            begin
                sec.push_back(8'hff);
                repeat (9) sec.push_back(8'hff);
                sec.push_back(8'($urandom_range(0, 127)));
            end
            else
                sec.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0 && sec.size() > 1)
        begin
            cut = $urandom_range(1, sec.size() - 1);
            while (sec.size() > cut)
                void'(sec.pop_back());
        end
    endtask

    task automatic random_phase(int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_section();
            no_gaps = ($urandom_range(0, 4) == 0);
            foreach (sec[i])
                send_byte(sec[i], i == sec.size() - 1);
            sent += sec.size();
        end
        no_gaps = 0;
    endtask

    // ---------------- directed table ----------------
    typedef struct {
        logic [7:0] b;
        bit         eos;
        bit         chk;
        logic [2:0] kind;
        logic [1:0] err;
    } row_t;

    row_t rows[] = '{
        '{8'h00, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'h00, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'hc0, 0, 1, EV_FIELD, ERR_NONE},       // lowest static index
        '{8'hff, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'h23, 0, 1, EV_FIELD, ERR_NONE},       // highest static index, 98
        '{8'h51, 0, 1, EV_NAMEREF, ERR_NONE},
        '{8'h03, 0, 1, EV_VAL_HDR, ERR_NONE},
        '{8'h61, 0, 1, EV_BYTE, ERR_NONE},
        '{8'h62, 0, 1, EV_BYTE, ERR_NONE},
        '{8'h63, 0, 1, EV_FIELD, ERR_NONE},
        '{8'h23, 0, 1, EV_NAME_HDR, ERR_NONE},
        '{8'h78, 0, 0, EV_BYTE, ERR_NONE},
        '{8'h79, 0, 0, EV_BYTE, ERR_NONE},
        '{8'h7a, 0, 0, EV_BYTE, ERR_NONE},
        '{8'h81, 0, 1, EV_VAL_HDR, ERR_NONE},     // Huffman value
        '{8'h0a, 1, 1, EV_SECTION, ERR_NONE},
        '{8'h01, 0, 1, EV_ERROR, ERR_DECOMP},     // nonzero insert count
        '{8'h00, 1, 0, EV_INDEXED, ERR_NONE},
        '{8'h00, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'h80, 0, 1, EV_ERROR, ERR_DECOMP},     // negative base
        '{8'hff, 1, 0, EV_INDEXED, ERR_NONE},
        '{8'h00, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'h00, 0, 0, EV_INDEXED, ERR_NONE},
        '{8'h10, 1, 1, EV_ERROR, ERR_DECOMP},     // post-base reference
        '{8'h00, 1, 1, EV_ERROR, ERR_DECOMP}      // truncated prefix
    };

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.section_byte = '0;
        in_ch.end_of_section = 1'b0;
        out_ch.ready = 1'b0;
        no_gaps = 0;
        lim_fields = 0;
        lim_size = 0;
        reset_section();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_byte(rows[i].b, rows[i].eos);
            if (rows[i].chk && (step_events.size() == 0 ||
                step_events[step_events.size() - 1].kind != rows[i].kind ||
                step_events[step_events.size() - 1].err != rows[i].err))
                report($sformatf("directed row %0d: model disagrees with table", i));
        end
        drain();

        random_phase(20);
        drain();
        write_reg(REG_MAX_FIELDS, 62'd2);
        write_reg(REG_MAX_SIZE, 62'd200);
        random_phase(20);
        drain();
        write_reg(REG_MAX_FIELDS, 62'd1);
        write_reg(REG_MAX_SIZE, 62'd40);
        random_phase(20);
        drain();
        write_reg(REG_MAX_FIELDS, 62'h0_ffff_ffff);
        write_reg(REG_MAX_SIZE, MASK62);
        random_phase(20);
        drain();
        write_reg(REG_MAX_FIELDS, 62'd0);
        write_reg(REG_MAX_SIZE, 62'd1);
        random_phase(10);
        drain();
        write_reg(REG_MAX_SIZE, 62'd0);
        random_phase(10);
        drain();

        if (mismatches == 0 && pending_events.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ qpack_static_field_section_parser.f @@
src/qsp_pkg.sv
src/qsp_if.sv
src/qsp_core.sv
src/qsp_out_queue.sv
src/qpack_static_field_section_parser.sv
src/qsp_checker.sv
dv/testbench.sv
